### rtl/mpt_pkg.sv
// Package for the memory pressure level tracker: widths, codes, types and
// the level re-evaluation function used by the core.
// No dependencies.
package mpt_pkg;

  localparam int MAX_LEVELS = 4;
  localparam int NUM_THR    = 4;
  localparam int THR_IDX_W  = $clog2(NUM_THR);
  localparam int CNT_W      = 32;
  localparam int LVL_W      = 3;
  localparam int FUNC_W     = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 32;

  typedef logic [CNT_W-1:0]     cnt_t;
  typedef cnt_t [NUM_THR-1:0]   thr_arr_t;
  typedef logic [LVL_W-1:0]     lvl_t;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_APPLY = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOMEM  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADCFG = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THR0        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR1        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR2        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR3        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd5;

  localparam lvl_t TOP_LEVEL = lvl_t'(MAX_LEVELS);

  typedef struct packed {
    lvl_t level;
    cnt_t lo;
    cnt_t hi;
  } eval_t;

  // Level is the first active watermark above the count; bounds are the
  // neighbouring watermarks widened by the debounce margin.
  function automatic eval_t mpt_reeval(thr_arr_t thr, lvl_t cnt, cnt_t deb, cnt_t f);
    eval_t           e;
    lvl_t            tgt;
    cnt_t            w;
    logic [CNT_W:0]  u;
    tgt = cnt;
    for (int i = NUM_THR - 1; i >= 0; i--) begin
      if ((lvl_t'(i) < cnt) && (thr[i] > f)) begin
        tgt = lvl_t'(i);
      end
    end
    e.level = tgt;
    e.lo    = '0;
    if ((tgt != '0) && (tgt <= lvl_t'(NUM_THR))) begin
      w = thr[THR_IDX_W'(tgt - lvl_t'(1))];
      e.lo = (w >= deb) ? (w - deb) : '0;
    end
    e.hi = '1;
    if ((tgt < cnt) && (tgt < lvl_t'(NUM_THR))) begin
      u = {1'b0, thr[THR_IDX_W'(tgt)]} + {1'b0, deb};
      e.hi = u[CNT_W] ? '1 : u[CNT_W-1:0];
    end
    return e;
  endfunction

endpackage

### rtl/memory_pressure_level_tracker_core.sv
// Result path: an input transfer is held in the input register, then in the result register on out_valid.
// Throughput: one item per cycle while out_ready is high; the path that sets it is the free-count
// add/subtract followed by four parallel watermark compares and bound select.
// Reset (synchronous, rst_n low): free count 0, level 1, bounds 0 / all ones,
// one watermark at 0 active, staged registers at their reset values.
// Top level of the memory pressure level tracker; uses mpt_pkg.
module memory_pressure_level_tracker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mpt_pkg::FUNC_W-1:0]      in_func,
  input  logic [mpt_pkg::CNT_W-1:0]       in_page_count,
  input  logic                            in_delay_ok,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mpt_pkg::STAT_W-1:0]      out_status,
  output logic [mpt_pkg::LVL_W-1:0]       out_level,
  output logic                            out_level_changed,
  output logic [mpt_pkg::CNT_W-1:0]       out_free_pages_now,
  output logic                            out_pages_available,
  // configuration
  input  logic                            cfg_we,
  input  logic [mpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpt_pkg::CFG_W-1:0]       cfg_wdata
);

  // input register
  logic                          s1_valid_r;
  logic [mpt_pkg::FUNC_W-1:0]    s1_func_r;
  mpt_pkg::cnt_t                 s1_n_r;
  logic                          s1_delay_r;

  // staged and active configuration
  mpt_pkg::thr_arr_t             reg_thr_r, act_thr_r, act_thr_nxt;
  mpt_pkg::lvl_t                 reg_cnt_r, act_cnt_r, act_cnt_nxt;
  mpt_pkg::cnt_t                 reg_deb_r, act_deb_r, act_deb_nxt;

  // tracker state
  mpt_pkg::cnt_t                 free_r, free_nxt;
  mpt_pkg::lvl_t                 level_r, level_nxt;
  mpt_pkg::cnt_t                 lo_r, lo_nxt;
  mpt_pkg::cnt_t                 hi_r, hi_nxt;

  // result register
  logic                          out_valid_r;
  logic [mpt_pkg::STAT_W-1:0]    status_r, status_nxt;
  logic                          changed_r, changed_nxt;
  mpt_pkg::lvl_t                 out_level_r;
  mpt_pkg::cnt_t                 out_free_r;

  logic                          advance;
  logic                          fire;
  logic [mpt_pkg::CNT_W:0]       sum;
  mpt_pkg::cnt_t                 f_sat;
  mpt_pkg::cnt_t                 f_dec;
  mpt_pkg::cnt_t                 f_a;
  mpt_pkg::eval_t                ev_a, ev_b, ev_c;
  logic                          cfg_ok;
  mpt_pkg::lvl_t                 lvl1;
  mpt_pkg::cnt_t                 up1;

  // handshake: the input register moves on whenever the result register frees
  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  // count arithmetic
  assign sum   = {1'b0, free_r} + {1'b0, s1_n_r};
  assign f_sat = sum[mpt_pkg::CNT_W] ? '1 : sum[mpt_pkg::CNT_W-1:0];
  assign f_dec = free_r - s1_n_r;
  assign f_a   = (s1_func_r == mpt_pkg::FUNC_FREE) ? f_sat : f_dec;

  // re-evaluation on the updated count, on the original count, and on the
  // staged configuration for apply
  assign ev_a = mpt_pkg::mpt_reeval(act_thr_r, act_cnt_r, act_deb_r, f_a);
  assign ev_b = mpt_pkg::mpt_reeval(act_thr_r, act_cnt_r, act_deb_r, free_r);
  assign ev_c = mpt_pkg::mpt_reeval(reg_thr_r, reg_cnt_r, reg_deb_r, free_r);

  // staged configuration check
  always_comb begin
    cfg_ok = (reg_cnt_r <= mpt_pkg::TOP_LEVEL);
    if ((reg_cnt_r != '0) && (reg_thr_r[0] < reg_deb_r)) begin
      cfg_ok = 1'b0;
    end
    for (int i = 1; i < mpt_pkg::NUM_THR; i++) begin
      if ((mpt_pkg::lvl_t'(i) < reg_cnt_r) && (reg_thr_r[i] <= reg_thr_r[i-1])) begin
        cfg_ok = 1'b0;
      end
    end
  end

  // item processing
  always_comb begin
    free_nxt    = free_r;
    level_nxt   = level_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    act_thr_nxt = act_thr_r;
    act_cnt_nxt = act_cnt_r;
    act_deb_nxt = act_deb_r;
    status_nxt  = mpt_pkg::STAT_OK;
    changed_nxt = 1'b0;
    lvl1        = level_r;
    up1         = hi_r;
    case (s1_func_r)
      mpt_pkg::FUNC_FREE: begin
        free_nxt = f_sat;
        if (f_sat >= hi_r) begin
          level_nxt   = ev_a.level;
          lo_nxt      = ev_a.lo;
          hi_nxt      = ev_a.hi;
          changed_nxt = 1'b1;
        end
      end
      mpt_pkg::FUNC_ALLOC: begin
        if (s1_n_r == '0) begin
          status_nxt = mpt_pkg::STAT_OK;
        end else if (s1_n_r == mpt_pkg::cnt_t'(1)) begin
          // single page: refused up front, never rolled back
          if (((level_r == '0) && s1_delay_r) || (free_r == '0)) begin
            status_nxt = mpt_pkg::STAT_NOMEM;
          end else begin
            free_nxt = f_dec;
            if (f_dec < lo_r) begin
              level_nxt   = ev_a.level;
              lo_nxt      = ev_a.lo;
              hi_nxt      = ev_a.hi;
              changed_nxt = 1'b1;
            end
          end
        end else if (s1_n_r > free_r) begin
          status_nxt = mpt_pkg::STAT_NOMEM;
        end else begin
          free_nxt = f_dec;
          if (f_dec < lo_r) begin
            level_nxt   = ev_a.level;
            lo_nxt      = ev_a.lo;
            hi_nxt      = ev_a.hi;
            changed_nxt = 1'b1;
            lvl1        = ev_a.level;
            up1         = ev_a.hi;
          end
          // out of memory with delay allowed: pages go back
          if ((lvl1 == '0) && s1_delay_r) begin
            free_nxt   = free_r;
            status_nxt = mpt_pkg::STAT_NOMEM;
            if (free_r >= up1) begin
              level_nxt   = ev_b.level;
              lo_nxt      = ev_b.lo;
              hi_nxt      = ev_b.hi;
              changed_nxt = 1'b1;
            end
          end
        end
      end
      mpt_pkg::FUNC_APPLY: begin
        if (cfg_ok) begin
          act_thr_nxt = reg_thr_r;
          act_cnt_nxt = reg_cnt_r;
          act_deb_nxt = reg_deb_r;
          level_nxt   = ev_c.level;
          lo_nxt      = ev_c.lo;
          hi_nxt      = ev_c.hi;
          changed_nxt = 1'b1;
        end else begin
          status_nxt = mpt_pkg::STAT_BADCFG;
        end
      end
      default: begin
        status_nxt = mpt_pkg::STAT_OK;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_func_r  <= in_func;
      s1_n_r     <= in_page_count;
      s1_delay_r <= in_delay_ok;
    end
  end

  // staged configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_thr_r <= '0;
      reg_cnt_r <= mpt_pkg::lvl_t'(1);
      reg_deb_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mpt_pkg::CFG_THR0:        reg_thr_r[0] <= cfg_wdata;
        mpt_pkg::CFG_THR1:        reg_thr_r[1] <= cfg_wdata;
        mpt_pkg::CFG_THR2:        reg_thr_r[2] <= cfg_wdata;
        mpt_pkg::CFG_THR3:        reg_thr_r[3] <= cfg_wdata;
        mpt_pkg::CFG_LEVEL_COUNT: reg_cnt_r    <= cfg_wdata[mpt_pkg::LVL_W-1:0];
        mpt_pkg::CFG_DEBOUNCE:    reg_deb_r    <= cfg_wdata;
        default:                  reg_cnt_r    <= reg_cnt_r;
      endcase
    end
  end

  // tracker state and active configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r    <= '0;
      level_r   <= mpt_pkg::lvl_t'(1);
      lo_r      <= '0;
      hi_r      <= '1;
      act_thr_r <= '0;
      act_cnt_r <= mpt_pkg::lvl_t'(1);
      act_deb_r <= '0;
    end else if (fire) begin
      free_r    <= free_nxt;
      level_r   <= level_nxt;
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      act_thr_r <= act_thr_nxt;
      act_cnt_r <= act_cnt_nxt;
      act_deb_r <= act_deb_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (fire) begin
      status_r    <= status_nxt;
      changed_r   <= changed_nxt;
      out_level_r <= level_nxt;
      out_free_r  <= free_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_level           = out_level_r;
  assign out_level_changed   = changed_r;
  assign out_free_pages_now  = out_free_r;
  assign out_pages_available = (out_level_r != '0);

endmodule

### rtl/mpt_checker.sv
// Port-level checks for the memory pressure level tracker result channel.
// Uses mpt_pkg; bound to memory_pressure_level_tracker_core below.
module mpt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mpt_pkg::STAT_W-1:0]  out_status,
  input logic [mpt_pkg::LVL_W-1:0]   out_level,
  input logic                        out_level_changed,
  input logic [mpt_pkg::CNT_W-1:0]   out_free_pages_now,
  input logic                        out_pages_available
);

  // no result straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_free_pages_now)
      && $stable(out_level) && $stable(out_status))
    else $error("stalled result changed");

  // availability flag follows the level
  a_avail: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (out_pages_available == (out_level != '0)))
    else $error("pages_available disagrees with level");

  // a rejected configuration never re-evaluates
  a_badcfg: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_status == mpt_pkg::STAT_BADCFG) |-> !out_level_changed)
    else $error("level re-evaluated on invalid configuration");

  // level never exceeds the top level, MAX_LEVELS
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (out_level <= mpt_pkg::TOP_LEVEL))
    else $error("level out of range");

endmodule

bind memory_pressure_level_tracker_core mpt_checker u_mpt_checker (.*);

### tb/testbench.sv
// Self-checking testbench for memory_pressure_level_tracker_core: random valid/ready
// traffic against an in-bench model of the free count and watermark level.
// Depends on mpt_pkg and the core RTL only.
module testbench;

  // function code the block ignores, and an index with no register behind it
  localparam logic [mpt_pkg::FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
  localparam logic [mpt_pkg::CFG_IDX_W-1:0] CFG_SPARE   = 3'd7;

  typedef struct {
    logic [mpt_pkg::FUNC_W-1:0] func;
    mpt_pkg::cnt_t              pages;
    logic                       delay;
  } tracker_request_t;

  typedef struct {
    logic [mpt_pkg::STAT_W-1:0] status;
    mpt_pkg::lvl_t              level;
    logic                       changed;
    mpt_pkg::cnt_t              free_now;
    logic                       avail;
  } tracker_outcome_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [mpt_pkg::FUNC_W-1:0]    in_func = mpt_pkg::FUNC_FREE;
  mpt_pkg::cnt_t                 in_page_count = '0;
  logic                          in_delay_ok = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [mpt_pkg::STAT_W-1:0]    out_status;
  mpt_pkg::lvl_t                 out_level;
  logic                          out_level_changed;
  mpt_pkg::cnt_t                 out_free_pages_now;
  logic                          out_pages_available;
  logic                          cfg_we = 1'b0;
  logic [mpt_pkg::CFG_IDX_W-1:0] cfg_index = mpt_pkg::CFG_THR0;
  logic [mpt_pkg::CFG_W-1:0]     cfg_wdata = '0;

  memory_pressure_level_tracker_core dut (.*);

  always #10 clk = ~clk;

  tracker_request_t pending_requests[$];
  tracker_outcome_t expected_outcomes[$];
  int               pushed_count = 0;
  int               accepted_count = 0;
  int               outcomes_seen = 0;
  int               mismatch_count = 0;
  logic             steady = 1'b0;

  // model state: staged registers, active settings, count and level
  mpt_pkg::cnt_t stg_thr [mpt_pkg::NUM_THR];
  mpt_pkg::lvl_t stg_levels;
  mpt_pkg::cnt_t stg_deb;
  mpt_pkg::cnt_t act_thr [mpt_pkg::NUM_THR];
  mpt_pkg::lvl_t act_levels;
  mpt_pkg::cnt_t act_deb;
  mpt_pkg::cnt_t free_cnt;
  mpt_pkg::lvl_t cur_level;
  mpt_pkg::cnt_t lo_bound;
  mpt_pkg::cnt_t hi_bound;

  task automatic note_failure(input string msg);
    mismatch_count++;
    $display("result %0d: %s", outcomes_seen, msg);
  endtask

  task automatic reset_model();
    int i;
    for (i = 0; i < mpt_pkg::NUM_THR; i++) begin
      stg_thr[i] = '0;
      act_thr[i] = '0;
    end
    stg_levels = 3'd1;
    act_levels = 3'd1;
    stg_deb    = '0;
    act_deb    = '0;
    free_cnt   = '0;
    cur_level  = 3'd1;
    lo_bound   = '0;
    hi_bound   = '1;
  endtask

  // Pick the first active watermark above the count, then widen the
  // neighbouring watermarks by the debounce margin to get the new bounds.
  task automatic relevel();
    mpt_pkg::lvl_t           tgt;
    logic                    hit;
    mpt_pkg::cnt_t           w;
    logic [mpt_pkg::CNT_W:0] sum;
    int                      i;
    tgt = act_levels;
    hit = 1'b0;
    for (i = 0; i < mpt_pkg::NUM_THR; i++) begin
      if (!hit && i < int'(act_levels) && act_thr[i] > free_cnt) begin
        tgt = mpt_pkg::lvl_t'(i);
        hit = 1'b1;
      end
    end
    cur_level = tgt;
    lo_bound = '0;
    if (tgt != '0) begin
      w = act_thr[int'(tgt) - 1];
      lo_bound = (w >= act_deb) ? w - act_deb : '0;
    end
    hi_bound = '1;
    if (int'(tgt) < int'(act_levels) && int'(tgt) < mpt_pkg::NUM_THR) begin
      sum = {1'b0, act_thr[int'(tgt)]} + {1'b0, act_deb};
      hi_bound = sum[mpt_pkg::CNT_W] ? '1 : sum[mpt_pkg::CNT_W-1:0];
    end
  endtask

  // staged settings must ascend and leave room for the debounce margin
  function automatic logic staged_ok();
    logic ok;
    int   i;
    ok = (stg_levels <= mpt_pkg::lvl_t'(mpt_pkg::MAX_LEVELS));
    if (ok && stg_levels != '0 && stg_thr[0] < stg_deb) ok = 1'b0;
    for (i = 1; i < mpt_pkg::NUM_THR; i++) begin
      if (i < int'(stg_levels) && stg_thr[i] <= stg_thr[i-1]) ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic predict_tracker(input tracker_request_t rq, output tracker_outcome_t res);
    logic [mpt_pkg::CNT_W:0]    sum;
    logic [mpt_pkg::STAT_W-1:0] st;
    logic                       chg;
    st  = mpt_pkg::STAT_OK;
    chg = 1'b0;
    case (rq.func)
      mpt_pkg::FUNC_FREE: begin
        sum = {1'b0, free_cnt} + {1'b0, rq.pages};
        free_cnt = sum[mpt_pkg::CNT_W] ? '1 : sum[mpt_pkg::CNT_W-1:0];
        if (free_cnt >= hi_bound) begin
          relevel();
          chg = 1'b1;
        end
      end
      mpt_pkg::FUNC_ALLOC: begin
        if (rq.pages == 1) begin
          // single page: refused when empty, or at level 0 with delay allowed
          if ((cur_level == '0 && rq.delay) || free_cnt == '0) begin
            st = mpt_pkg::STAT_NOMEM;
          end else begin
            free_cnt = free_cnt - 1'b1;
            if (free_cnt < lo_bound) begin
              relevel();
              chg = 1'b1;
            end
          end
        end else if (rq.pages > free_cnt) begin
          st = mpt_pkg::STAT_NOMEM;
        end else if (rq.pages != '0) begin
          free_cnt = free_cnt - rq.pages;
          if (free_cnt < lo_bound) begin
            relevel();
            chg = 1'b1;
          end
          // dropped to level 0 with delay allowed: pages go back, refused
          if (cur_level == '0 && rq.delay) begin
            free_cnt = free_cnt + rq.pages;
            if (free_cnt >= hi_bound) begin
              relevel();
              chg = 1'b1;
            end
            st = mpt_pkg::STAT_NOMEM;
          end
        end
      end
      mpt_pkg::FUNC_APPLY: begin
        if (staged_ok()) begin
          act_thr    = stg_thr;
          act_levels = stg_levels;
          act_deb    = stg_deb;
          relevel();
          chg = 1'b1;
        end else begin
          st = mpt_pkg::STAT_BADCFG;
        end
      end
      default: begin
      end
    endcase
    res.status   = st;
    res.level    = cur_level;
    res.changed  = chg;
    res.free_now = free_cnt;
    res.avail    = (cur_level != '0);
  endtask

  // Driver: next request once the previous transfer has gone, random gaps
  always @(posedge clk) begin : driver
    tracker_request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
        nxt = pending_requests.pop_front();
        in_valid      <= 1'b1;
        in_func       <= nxt.func;
        in_page_count <= nxt.pages;
        in_delay_ok   <= nxt.delay;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer, then predict each input transfer
  always @(posedge clk) begin : monitor
    tracker_request_t rq;
    tracker_outcome_t want;
    out_ready <= steady || ($urandom_range(99) >= 9);
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) begin
          note_failure("result transfer with nothing expected");
        end else begin
          want = expected_outcomes.pop_front();
          if (out_status != want.status)
            note_failure($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_level != want.level)
            note_failure($sformatf("level %0d, expected %0d", out_level, want.level));
          if (out_level_changed != want.changed)
            note_failure($sformatf("level_changed %0d, expected %0d",
                                   out_level_changed, want.changed));
          if (out_free_pages_now != want.free_now)
            note_failure($sformatf("free_pages_now %0h, expected %0h",
                                   out_free_pages_now, want.free_now));
          if (out_pages_available != want.avail)
            note_failure($sformatf("pages_available %0d, expected %0d",
                                   out_pages_available, want.avail));
        end
        outcomes_seen++;
      end
      if (in_valid && in_ready) begin
        rq.func  = in_func;
        rq.pages = in_page_count;
        rq.delay = in_delay_ok;
        predict_tracker(rq, want);
        expected_outcomes.insert(expected_outcomes.size(), want);
        accepted_count++;
      end
    end
  end

  task automatic queue_item(input logic [mpt_pkg::FUNC_W-1:0] f, input mpt_pkg::cnt_t n,
                            input logic d);
    tracker_request_t rq;
    rq.func  = f;
    rq.pages = n;
    rq.delay = d;
    pending_requests.insert(pending_requests.size(), rq);
    pushed_count++;
  endtask

  // all requests taken and answered, plus a short settle for the pipeline
  task automatic wait_idle();
    while (accepted_count != pushed_count || expected_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mpt_pkg::CFG_IDX_W-1:0] idx, input mpt_pkg::cnt_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      mpt_pkg::CFG_THR0, mpt_pkg::CFG_THR1,
      mpt_pkg::CFG_THR2, mpt_pkg::CFG_THR3: stg_thr[idx[mpt_pkg::THR_IDX_W-1:0]] = val;
      mpt_pkg::CFG_LEVEL_COUNT: stg_levels = val[mpt_pkg::LVL_W-1:0];
      mpt_pkg::CFG_DEBOUNCE:    stg_deb = val;
      default: begin
      end
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One phase: fresh watermarks of a given scale, drain, apply, then a
  // random walk of frees and allocations around the watermarks.
  //   0 small spacing, 1 spacing near the full range,
  //   2 top watermark at all ones with a wide margin, 3 first watermark at 0
  task automatic random_phase(input int mode, input int n_items);
    mpt_pkg::cnt_t              gap, base, deb, start, n;
    mpt_pkg::cnt_t              marks [mpt_pkg::NUM_THR];
    int                         levels, i, r;
    logic [mpt_pkg::FUNC_W-1:0] f;
    wait_idle();
    case (mode)
      1: begin
        gap  = $urandom_range(32'h1000_0000, 32'h3000_0000);
        deb  = $urandom_range(0, gap / 2);
        base = deb + $urandom_range(0, 32'h1000_0000);
      end
      2: begin
        gap  = $urandom_range(16, 2000);
        deb  = $urandom_range(gap, 32'h0010_0000);
        base = 32'hFFFF_FFFF - 3 * gap;
      end
      3: begin
        gap  = $urandom_range(4, 300);
        deb  = '0;
        base = '0;
      end
      default: begin
        gap  = $urandom_range(4, 300);
        deb  = $urandom_range(0, gap / 2);
        base = deb + $urandom_range(0, gap);
      end
    endcase
    levels = (mode == 2) ? 4 : (($urandom_range(99) < 6) ? 0 : $urandom_range(1, 4));
    for (i = 0; i < mpt_pkg::NUM_THR; i++) begin
      if (i < levels || mode == 2) begin
        marks[i] = base + i * gap;
        if (mode != 2 && i > 0) marks[i] = marks[i] + $urandom_range(0, gap / 2);
      end else begin
        marks[i] = $urandom;
      end
    end
    // occasionally break the settings so the apply is refused
    r = $urandom_range(99);
    if (r < 3) levels = $urandom_range(5, 7);
    else if (r < 6) marks[1] = marks[0];
    else if (r < 9) deb = marks[0] + 1;
    if ($urandom_range(9) == 0) write_reg(CFG_SPARE, $urandom);
    write_reg(mpt_pkg::CFG_THR0, marks[0]);
    write_reg(mpt_pkg::CFG_THR1, marks[1]);
    write_reg(mpt_pkg::CFG_THR2, marks[2]);
    write_reg(mpt_pkg::CFG_THR3, marks[3]);
    write_reg(mpt_pkg::CFG_LEVEL_COUNT, mpt_pkg::cnt_t'(levels));
    write_reg(mpt_pkg::CFG_DEBOUNCE, deb);
    end_writes();
    // bring the count down to zero, apply, then jump just below the watermarks
    start = (base > 2 * gap) ? base - 2 * gap : '0;
    queue_item(mpt_pkg::FUNC_ALLOC, free_cnt, 1'b0);
    queue_item(mpt_pkg::FUNC_APPLY, $urandom, $urandom_range(0, 1));
    queue_item(mpt_pkg::FUNC_FREE, start, $urandom_range(0, 1));
    for (i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 46) f = mpt_pkg::FUNC_FREE;
      else if (r < 94) f = mpt_pkg::FUNC_ALLOC;
      else if (r < 98) f = mpt_pkg::FUNC_APPLY;
      else f = FUNC_UNUSED;
      r = $urandom_range(99);
      if (r < 10) n = $urandom_range(0, 2);
      else if (r < 14) n = $urandom;
      else if (r < 16) n = '1;
      else n = $urandom_range(0, gap);
      queue_item(f, n, $urandom_range(0, 1));
    end
  endtask

  initial begin
    int ph;
    reset_model();
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty allocations, saturating free, unused code
    queue_item(mpt_pkg::FUNC_ALLOC, '0, 1'b0);
    queue_item(mpt_pkg::FUNC_ALLOC, 32'd1, 1'b0);
    queue_item(mpt_pkg::FUNC_ALLOC, 32'd5, 1'b1);
    queue_item(mpt_pkg::FUNC_FREE, '1, 1'b0);
    queue_item(mpt_pkg::FUNC_FREE, 32'd10, 1'b1);
    queue_item(mpt_pkg::FUNC_ALLOC, '1, 1'b0);
    queue_item(FUNC_UNUSED, '1, 1'b1);
    queue_item(mpt_pkg::FUNC_APPLY, '0, 1'b0);

    // four watermarks: walk through level 0 refusals and level changes
    wait_idle();
    write_reg(mpt_pkg::CFG_THR0, 32'd100);
    write_reg(mpt_pkg::CFG_THR1, 32'd200);
    write_reg(mpt_pkg::CFG_THR2, 32'd300);
    write_reg(mpt_pkg::CFG_THR3, 32'd400);
    write_reg(mpt_pkg::CFG_LEVEL_COUNT, 32'd4);
    write_reg(mpt_pkg::CFG_DEBOUNCE, 32'd10);
    end_writes();
    queue_item(mpt_pkg::FUNC_APPLY, '0, 1'b0);
    queue_item(mpt_pkg::FUNC_ALLOC, 32'd1, 1'b1);
    queue_item(mpt_pkg::FUNC_FREE, 32'd50, 1'b0);
    queue_item(mpt_pkg::FUNC_ALLOC, 32'd1, 1'b1);
    queue_item(mpt_pkg::FUNC_ALLOC, 32'd1, 1'b0);
    queue_item(mpt_pkg::FUNC_ALLOC, 32'd5, 1'b1);
    queue_item(mpt_pkg::FUNC_FREE, 32'd200, 1'b0);
    queue_item(mpt_pkg::FUNC_ALLOC, 32'd100, 1'b0);
    queue_item(mpt_pkg::FUNC_FREE, '1, 1'b0);
    queue_item(mpt_pkg::FUNC_ALLOC, '1, 1'b1);
    queue_item(mpt_pkg::FUNC_ALLOC, '1, 1'b0);

    // refused settings: too many levels, equal watermarks, margin too wide
    wait_idle();
    write_reg(mpt_pkg::CFG_LEVEL_COUNT, 32'd7);
    end_writes();
    queue_item(mpt_pkg::FUNC_APPLY, '0, 1'b0);
    wait_idle();
    write_reg(mpt_pkg::CFG_LEVEL_COUNT, 32'd4);
    write_reg(mpt_pkg::CFG_THR1, 32'd100);
    end_writes();
    queue_item(mpt_pkg::FUNC_APPLY, '0, 1'b0);
    wait_idle();
    write_reg(mpt_pkg::CFG_THR1, 32'd200);
    write_reg(mpt_pkg::CFG_DEBOUNCE, 32'd101);
    end_writes();
    queue_item(mpt_pkg::FUNC_APPLY, '0, 1'b0);
    // margin equal to the first watermark is accepted
    wait_idle();
    write_reg(mpt_pkg::CFG_DEBOUNCE, 32'd100);
    end_writes();
    queue_item(mpt_pkg::FUNC_APPLY, '0, 1'b0);
    // no watermarks at all, with the widest margin
    wait_idle();
    write_reg(mpt_pkg::CFG_LEVEL_COUNT, 32'd0);
    write_reg(mpt_pkg::CFG_DEBOUNCE, '1);
    end_writes();
    queue_item(mpt_pkg::FUNC_APPLY, '0, 1'b1);

    for (ph = 0; ph < 14; ph++) begin
      steady = (ph == 6);
      random_phase((ph % 2 == 0) ? 0 : ((ph / 2) % 3 + 1), 97);
    end
    wait_idle();
    steady = 1'b0;
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20 * 500000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
